FILE: hdl/pbrc_pkg.sv
// -----------------------------------------------------------------------------
// pbrc_pkg
// Types and constants shared by the packed bit range copy block: channel
// payloads, configuration register indexes and result queue sizing.
// -----------------------------------------------------------------------------
package pbrc_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int ADDR_W     = 29;
    localparam int REG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_START_BIT = 2'd0,
        CFG_DST_START_BIT = 2'd1,
        CFG_BIT_COUNT     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_BITS-1:0] src_byte;
        logic                 start_of_run;
    } t_src_word;

    typedef struct packed {
        logic [ADDR_W-1:0]    dst_byte_addr;
        logic [BYTE_BITS-1:0] dst_data;
        logic [BYTE_BITS-1:0] write_mask;
        logic                 last_write;
    } t_dst_word;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  not_empty;
        logic                  room_for_two;
    } t_fifo_status;

endpackage

FILE: hdl/pbrc_stream_if.sv
// -----------------------------------------------------------------------------
// pbrc_stream_if
// Valid/ready channel carrying one word of a given payload type.
// -----------------------------------------------------------------------------
interface pbrc_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/pbrc_result_fifo.sv
// -----------------------------------------------------------------------------
// pbrc_result_fifo
// Small result queue: takes up to two destination words per cycle and hands
// out one per cycle from a registered slot.
// -----------------------------------------------------------------------------
module pbrc_result_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pbrc_pkg::t_dst_word [1:0]   i_wr_word,
    input  logic [1:0]                  i_wr_cnt,
    input  logic                        i_pop,
    output pbrc_pkg::t_dst_word         o_rd_word,
    output pbrc_pkg::t_fifo_status      o_status
);
    import pbrc_pkg::*;

    t_dst_word             r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic [FIFO_PTR_W-1:0] wr_ptr_b;
    logic                  pop_ok;

    assign pop_ok   = i_pop && (r_count != '0);
    assign wr_ptr_b = r_wr_ptr + FIFO_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_wr_cnt);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop_ok);
        n_count  = r_count + FIFO_CNT_W'(i_wr_cnt) - FIFO_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr_word[0];
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[wr_ptr_b] <= i_wr_word[1];
        end
    end

    assign o_rd_word             = r_mem[r_rd_ptr];
    assign o_status.count        = r_count;
    assign o_status.not_empty    = (r_count != '0);
    assign o_status.room_for_two = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

FILE: hdl/packed_bit_range_copy.sv
// -----------------------------------------------------------------------------
// packed_bit_range_copy
// Bit-granular copy engine: realigns a stream of source bytes onto a
// destination bit offset and emits masked byte writes.
// -----------------------------------------------------------------------------
// The block takes one source byte per clock cycle while the result queue has
// room. A byte is held in an input register, then the funnel shift and write
// generation run in a single pass and place zero, one or two destination
// words into a four-entry result queue, from which one word leaves per cycle
// while the receiver is ready. A byte can produce two writes (a partial head
// write followed by the tail of a short run), so the input is held off while
// fewer than two queue entries are free: sustained rate is one byte per cycle
// whenever the run lengths keep the output at or below one write per cycle and
// the receiver accepts it. Configuration is sampled at each start of run.
// -----------------------------------------------------------------------------
module packed_bit_range_copy (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pbrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pbrc_pkg::REG_W-1:0]         i_cfg_data,
    pbrc_stream_if.sink                        i_src,
    pbrc_stream_if.source                      o_dst
);
    import pbrc_pkg::*;

    // Configuration registers.
    logic [REG_W-1:0]     r_src_start_bit;
    logic [REG_W-1:0]     r_dst_start_bit;
    logic [REG_W-1:0]     r_bit_count;

    // Input register.
    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic                 r_in_sor;

    // Run state.
    logic [15:0]          r_acc, n_acc;
    logic [4:0]           r_accb, n_accb;
    logic [2:0]           r_head, n_head;
    logic [REG_W-1:0]     r_bits_left, n_bits_left;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_active, n_active;

    t_dst_word [1:0]      res_word;
    logic [1:0]           res_cnt;
    logic                 fire;
    t_dst_word            rd_word;
    t_fifo_status         fifo_st;

    assign fire        = r_in_valid && fifo_st.room_for_two;
    assign i_src.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_start_bit <= '0;
            r_dst_start_bit <= '0;
            r_bit_count     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_START_BIT: r_src_start_bit <= i_cfg_data;
                CFG_DST_START_BIT: r_dst_start_bit <= i_cfg_data;
                CFG_BIT_COUNT:     r_bit_count     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_src.valid && i_src.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_in_byte <= i_src.payload.src_byte;
            r_in_sor  <= i_src.payload.start_of_run;
        end
    end

    // Merge the byte into the accumulator, then retire up to two
    // destination bytes that are complete.
    always_comb begin
        logic [15:0]       acc;
        logic [4:0]        accb;
        logic [2:0]        head;
        logic [REG_W-1:0]  bl;
        logic [ADDR_W-1:0] addr;
        logic              act;
        logic              go;
        logic [2:0]        soff;
        logic [2:0]        doff;
        logic [3:0]        room;
        logic [3:0]        need;
        logic [4:0]        have;
        logic [8:0]        ones;
        logic [7:0]        mask;
        logic              last;

        acc  = r_acc;
        accb = r_accb;
        head = r_head;
        bl   = r_bits_left;
        addr = r_addr;
        act  = r_active;
        go   = 1'b0;
        soff = r_src_start_bit[2:0];
        doff = r_dst_start_bit[2:0];
        room = '0;
        need = '0;
        have = '0;
        ones = '0;
        mask = '0;
        last = 1'b0;
        res_word = '0;
        res_cnt  = 2'd0;

        if (r_in_sor) begin
            addr = r_dst_start_bit[REG_W-1:3];
            bl   = r_bit_count;
            head = doff;
            acc  = '0;
            accb = '0;
            if (r_bit_count == '0) begin
                act = 1'b0;
            end else begin
                act  = 1'b1;
                acc  = 16'(({8'd0, r_in_byte} >> soff) << doff);
                accb = {2'b00, doff} + 5'd8 - {2'b00, soff};
            end
            go = act;
        end else if (r_active) begin
            acc  = r_acc | (16'(r_in_byte) << r_accb[2:0]);
            accb = {2'b00, r_accb[2:0]} + 5'd8;
            go   = 1'b1;
        end

        for (int k = 0; k < 2; k++) begin
            if (go && act) begin
                room = 4'd8 - {1'b0, head};
                need = (bl < {28'd0, room}) ? bl[3:0] : room;
                have = accb - {2'b00, head};
                if (have < {1'b0, need}) begin
                    go = 1'b0;
                end else begin
                    ones = (9'd1 << need) - 9'd1;
                    mask = ones[7:0] << head;
                    last = (bl == {28'd0, need});
                    res_word[k].dst_byte_addr = addr;
                    res_word[k].dst_data      = acc[7:0] & mask;
                    res_word[k].write_mask    = mask;
                    res_word[k].last_write    = last;
                    res_cnt = res_cnt + 2'd1;
                    bl = bl - {28'd0, need};
                    if (last) begin
                        act  = 1'b0;
                        acc  = '0;
                        accb = '0;
                        head = '0;
                    end else begin
                        acc  = acc >> BYTE_BITS;
                        accb = accb - 5'd8;
                        head = '0;
                        addr = addr + ADDR_W'(1);
                    end
                end
            end
        end

        n_acc       = acc;
        n_accb      = accb;
        n_head      = head;
        n_bits_left = bl;
        n_addr      = addr;
        n_active    = act;
        if (!fire) begin
            res_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_accb      <= '0;
            r_head      <= '0;
            r_bits_left <= '0;
            r_addr      <= '0;
            r_active    <= 1'b0;
        end else if (fire) begin
            r_acc       <= n_acc;
            r_accb      <= n_accb;
            r_head      <= n_head;
            r_bits_left <= n_bits_left;
            r_addr      <= n_addr;
            r_active    <= n_active;
        end
    end

    pbrc_result_fifo u_result_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_word (res_word),
        .i_wr_cnt  (res_cnt),
        .i_pop     (o_dst.valid && o_dst.ready),
        .o_rd_word (rd_word),
        .o_status  (fifo_st)
    );

    assign o_dst.valid   = fifo_st.not_empty;
    assign o_dst.payload = rd_word;

    // The queue never holds more words than it has entries.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_st.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // A delivered write always touches at least one bit.
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst.valid |-> (o_dst.payload.write_mask != 8'd0))
        else $error("empty write mask");

    // Data bits outside the mask are zero.
    a_data_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst.valid |-> ((o_dst.payload.dst_data & ~o_dst.payload.write_mask) == 8'd0))
        else $error("data outside write mask");

    // A held byte is not dropped while the queue lacks room.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("input byte lost while stalled");

endmodule

FILE: bench/pbrc_write_check.sv
// -----------------------------------------------------------------------------
// pbrc_write_check
// Watches the configuration port and both word channels of the packed bit
// range copy block, predicts every masked destination write from the
// accepted source words and compares each write leaving the block with the
// oldest one predicted.
// -----------------------------------------------------------------------------
module pbrc_write_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pbrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pbrc_pkg::REG_W-1:0]     i_cfg_data,
    input  logic                           i_src_valid,
    input  logic                           i_src_ready,
    input  pbrc_pkg::t_src_word            i_src_word,
    input  logic                           i_dst_valid,
    input  logic                           i_dst_ready,
    input  pbrc_pkg::t_dst_word            i_dst_word,
    output int                             o_mismatches,
    output int                             o_writes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import pbrc_pkg::*;

    logic [REG_W-1:0]  src_start_q;
    logic [REG_W-1:0]  dst_start_q;
    logic [REG_W-1:0]  bit_count_q;

    logic [15:0]       acc;
    logic [4:0]        acc_bits;
    logic [2:0]        head_off;
    logic [31:0]       bits_left;
    logic [ADDR_W-1:0] cur_addr;
    logic              in_run;

    t_dst_word         owed_writes[$];

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    // Folds one source word into the realignment state and queues the
    // destination writes that it completes.
    task automatic realign_byte(input logic [7:0] b, input logic sor);
        int unsigned room;
        int unsigned need;
        int unsigned have;
        int unsigned made;
        logic [7:0]  mask;
        logic        last;
        logic        take;
        t_dst_word   w;
        take = 1'b0;
        made = 0;
        if (sor) begin
            cur_addr  = dst_start_q[REG_W-1:3];
            bits_left = bit_count_q;
            head_off  = dst_start_q[2:0];
            acc       = (16'(b) >> src_start_q[2:0]) << dst_start_q[2:0];
            acc_bits  = 5'(dst_start_q[2:0]) + 5'd8 - 5'(src_start_q[2:0]);
            in_run    = (bit_count_q != '0);
            take      = in_run;
            if (!in_run) begin
                acc      = '0;
                acc_bits = '0;
            end
        end else if (in_run) begin
            acc      = acc | (16'(b) << acc_bits[2:0]);
            acc_bits = 5'(acc_bits[2:0]) + 5'd8;
            take     = 1'b1;
        end
        while (take && in_run && made < 2) begin
            room = BYTE_BITS - head_off;
            need = (bits_left < room) ? bits_left : room;
            have = acc_bits - head_off;
            if (have < need) begin
                take = 1'b0;
            end else begin
                last            = (bits_left == need);
                mask            = 8'(((32'd1 << need) - 32'd1) << head_off);
                w.dst_byte_addr = cur_addr;
                w.dst_data      = acc[7:0] & mask;
                w.write_mask    = mask;
                w.last_write    = last;
                owed_writes.push_back(w);
                made++;
                bits_left = bits_left - need;
                head_off  = '0;
                if (last) begin
                    in_run   = 1'b0;
                    acc      = '0;
                    acc_bits = '0;
                end else begin
                    acc      = acc >> BYTE_BITS;
                    acc_bits = acc_bits - 5'd8;
                    cur_addr = cur_addr + 1'b1;
                end
            end
        end
    endtask

    task automatic compare_write(input t_dst_word got);
        t_dst_word want;
        if (owed_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write to %h data %h mask %h",
                                      got.dst_byte_addr, got.dst_data, got.write_mask));
        end else begin
            want = owed_writes.pop_front();
            if (got.dst_byte_addr !== want.dst_byte_addr)
                report_mismatch($sformatf("address %h, expected %h",
                                          got.dst_byte_addr, want.dst_byte_addr));
            if (got.dst_data !== want.dst_data)
                report_mismatch($sformatf("data %h at %h, expected %h",
                                          got.dst_data, want.dst_byte_addr, want.dst_data));
            if (got.write_mask !== want.write_mask)
                report_mismatch($sformatf("mask %h at %h, expected %h",
                                          got.write_mask, want.dst_byte_addr, want.write_mask));
            if (got.last_write !== want.last_write)
                report_mismatch($sformatf("last flag %b at %h, expected %b",
                                          got.last_write, want.dst_byte_addr, want.last_write));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_start_q = '0;
            dst_start_q = '0;
            bit_count_q = '0;
            acc         = '0;
            acc_bits    = '0;
            head_off    = '0;
            bits_left   = '0;
            cur_addr    = '0;
            in_run      = 1'b0;
            owed_writes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_START_BIT: src_start_q = i_cfg_data;
                    CFG_DST_START_BIT: dst_start_q = i_cfg_data;
                    CFG_BIT_COUNT:     bit_count_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_src_valid && i_src_ready)
                realign_byte(i_src_word.src_byte, i_src_word.start_of_run);
            if (i_dst_valid && i_dst_ready)
                compare_write(i_dst_word);
        end
        o_writes_owed = owed_writes.size();
    end

endmodule

FILE: bench/packed_bit_range_copy_tb.sv
// -----------------------------------------------------------------------------
// packed_bit_range_copy_tb
// Drives source words and register settings into the packed bit range copy
// block: a directed opening over offsets, partial writes, restarts and address
// wrap, then random runs under random idling on both channels, with long
// receiver hold-offs to fill the block. The write checker does the comparing.
// -----------------------------------------------------------------------------
module packed_bit_range_copy_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbrc_pkg::*;

    localparam int ITEM_TARGET     = 1550;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HUGE_RUN_BYTES  = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [REG_W-1:0]     cfg_data;

    int                   mismatches;
    int                   writes_owed;
    int                   items_sent;
    int                   hold_req;
    int                   hold_done;
    bit                   src_steady;
    logic [REG_W-1:0]     cur_src_start;
    logic [REG_W-1:0]     cur_bit_count;

    pbrc_stream_if #(.t_payload(t_src_word)) src_ch ();
    pbrc_stream_if #(.t_payload(t_dst_word)) dst_ch ();

    packed_bit_range_copy dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_src      (src_ch.sink),
        .o_dst      (dst_ch.source)
    );

    pbrc_write_check u_write_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_src_valid   (src_ch.valid),
        .i_src_ready   (src_ch.ready),
        .i_src_word    (src_ch.payload),
        .i_dst_valid   (dst_ch.valid),
        .i_dst_ready   (dst_ch.ready),
        .i_dst_word    (dst_ch.payload),
        .o_mismatches  (mismatches),
        .o_writes_owed (writes_owed)
    );

    always #5 clk = ~clk;

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] fill_byte(input int fill);
        if (fill == FILL_ONES) return 8'hff;
        if (fill == FILL_ZEROS) return 8'h00;
        return 8'($urandom);
    endfunction

    // Source words needed to cover a run of the current setting, or a random short length for huge runs.
    function automatic int unsigned run_bytes();
        longint unsigned span;
        span = longint'(cur_src_start[2:0]) + longint'(cur_bit_count) + 7;
        if (span / 8 > HUGE_RUN_BYTES * 100) return $urandom_range(1, HUGE_RUN_BYTES);
        return int'(span / 8);
    endfunction

    // Receiver: random stalls, steady stretches, and a long hold-off on request.
    initial begin
        int stall_left;
        int mode_left;
        bit sink_steady;
        stall_left  = 0;
        mode_left   = 0;
        sink_steady = 1'b0;
        hold_done   = 0;
        dst_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req != hold_done) begin
                dst_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_done = hold_req;
            end else if (stall_left > 0) begin
                dst_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                dst_ch.ready <= 1'b1;
                if (mode_left == 0) begin
                    sink_steady = ($urandom_range(0, 3) == 0);
                    mode_left   = $urandom_range(20, 150);
                end else begin
                    mode_left--;
                end
                if (!sink_steady) stall_left = pick_gap();
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for the next word.
    task automatic put_byte(input logic [7:0] b, input logic sor, input bit counts);
        int        gap;
        t_src_word word;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            src_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word.src_byte     = b;
        word.start_of_run = sor;
        src_ch.valid   <= 1'b1;
        src_ch.payload <= word;
        do @(posedge clk); while (!src_ch.ready);
        @(negedge clk);
        if (counts) items_sent++;
    endtask

    task automatic send_run(input int unsigned nbytes, input int unsigned extra,
                            input int fill);
        for (int unsigned i = 0; i < nbytes; i++)
            put_byte(fill_byte(fill), i == 0, 1'b1);
        repeat (extra) put_byte(8'($urandom), 1'b0, 1'b0);
    endtask

    // Stops offering words and waits until every predicted write has left and
    // any word still inside the block has had time to pass through.
    task automatic settle();
        src_ch.valid <= 1'b0;
        while (writes_owed != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_regs(input logic [REG_W-1:0] src_start,
                                input logic [REG_W-1:0] dst_start,
                                input logic [REG_W-1:0] count,
                                input bit touch_spare);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SRC_START_BIT;
        cfg_data <= src_start;
        @(negedge clk);
        cfg_idx  <= CFG_DST_START_BIT;
        cfg_data <= dst_start;
        @(negedge clk);
        cfg_idx  <= CFG_BIT_COUNT;
        cfg_data <= count;
        @(negedge clk);
        if (touch_spare) begin
            cfg_idx  <= CFG_SPARE_IDX;
            cfg_data <= $urandom;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        cur_src_start = src_start;
        cur_bit_count = count;
    endtask

    initial begin
        logic [REG_W-1:0] src_start;
        logic [REG_W-1:0] dst_start;
        logic [REG_W-1:0] count;
        int               r;
        int               runs;
        int unsigned      nb;
        bit               squeeze;

        items_sent    = 0;
        hold_req      = 0;
        src_steady    = 1'b0;
        cur_src_start = '0;
        cur_bit_count = '0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_SRC_START_BIT;
        cfg_data       <= '0;
        src_ch.valid   <= 1'b0;
        src_ch.payload <= '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Zero-length run straight after reset, then a stray word while idle.
        send_run(1, 1, FILL_ONES);
        // Misaligned source and destination with surplus bits and a trailing word.
        program_regs(32'd5, 32'd3, 32'd12, 1'b0);
        send_run(run_bytes(), 1, FILL_ONES);
        program_regs(32'd0, 32'd0, 32'd8, 1'b0);
        send_run(1, 0, FILL_ZEROS);
        send_run(1, 0, FILL_ONES);
        // A single word that yields both a head write and the closing write.
        program_regs(32'd0, 32'd7, 32'd2, 1'b0);
        send_run(1, 0, FILL_ONES);
        // A run abandoned part-way by a fresh start of run.
        program_regs(32'd3, 32'h13, 32'd40, 1'b0);
        send_run(2, 0, FILL_RANDOM);
        send_run(run_bytes(), 0, FILL_RANDOM);
        // Destination address wrapping past the top of the address space.
        program_regs(32'hffff_ffff, 32'hffff_fffd, 32'd20, 1'b1);
        send_run(run_bytes(), 0, FILL_RANDOM);
        // Largest bit count: the run never completes and is left open.
        program_regs(32'd7, 32'd0, 32'hffff_ffff, 1'b0);
        send_run(3, 0, FILL_ONES);

        while (items_sent < ITEM_TARGET) begin
            squeeze   = (hold_req == 0 && items_sent >= 400) ||
                        (hold_req == 1 && items_sent >= 1100);
            src_start = $urandom;
            dst_start = $urandom;
            r         = $urandom_range(0, 99);
            if (squeeze)     count = $urandom_range(600, 900);
            else if (r < 55) count = $urandom_range(1, 24);
            else if (r < 82) count = $urandom_range(25, 96);
            else if (r < 92) count = $urandom_range(97, 400);
            else if (r < 96) count = '0;
            else             count = 32'hffff_ffff - $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0)
                dst_start = {29'h1fff_ffff - 29'($urandom_range(0, 1)), 3'($urandom)};
            program_regs(src_start, dst_start, count, $urandom_range(0, 7) == 0);
            src_steady = squeeze || ($urandom_range(0, 3) == 0);
            // The receiver now holds off while a long run keeps arriving.
            if (squeeze) hold_req++;
            runs = squeeze ? 1 : $urandom_range(1, 4);
            repeat (runs) begin
                r  = $urandom_range(0, 99);
                nb = run_bytes();
                if (r < 80) begin
                    send_run(nb, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                             ($urandom_range(0, 9) == 0) ?
                                 $urandom_range(FILL_ONES, FILL_ZEROS) : FILL_RANDOM);
                end else if (r < 90) begin
                    send_run($urandom_range(1, nb), 0, FILL_RANDOM);
                end else begin
                    repeat ($urandom_range(1, 4))
                        put_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0);
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && writes_owed == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
